// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Entry layout, the per-cycle command handed to every cell, and the
// ordering rule used by the cell compare.
// ----------------------------------------------------------------------------
package spq_pkg;

   // number of cells in the chain
   localparam int DEPTH = 64;
   // count register holds 0..DEPTH
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int PRIO_W = 8;
   localparam int ARR_W  = 16;
   localparam int TAG_W  = 16;
   localparam int OCC_W  = 7;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [ARR_W-1:0]  arr;
      logic [TAG_W-1:0]  tag;
   } spq_entry_type;

   // command broadcast to all cells for one accepted beat
   typedef struct packed {
      logic ins;
      logic rem;
   } spq_ctl_type;

   // true when entry a is served before stored entry b (ties go after)
   function automatic logic goes_before(spq_entry_type a, spq_entry_type b);
      logic res;
      if (a.prio != b.prio) begin
         res = (a.prio > b.prio);
      end else begin
         res = (a.arr < b.arr);
      end
      return res;
   endfunction

endpackage

// ===== rtl/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry, compares it against the incoming entry, and on each
// command shifts toward the tail (insert) or the head (remove).
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  spq_ctl_type   ctl,
   input  logic          occupied,
   input  spq_entry_type new_entry,
   input  spq_entry_type left_entry,
   input  logic          left_before,
   input  spq_entry_type right_entry,
   output spq_entry_type entry_ff,
   output logic          lands
);

   spq_entry_type entry_in;

   // new entry lands at or ahead of this slot
   assign lands = !occupied || goes_before(new_entry, entry_ff);

   // slot update: take from the left neighbor, the new entry, or the right
   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins && lands) begin
         entry_in = left_before ? left_entry : new_entry;
      end else if (ctl.rem) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// A result beat appears in the cycle after its request beat is taken.
// Throughput: one insert or remove per cycle while the output register
// frees as it is taken; every cell compares and shifts in the same cycle.
// Reset clears the entry count and the response valid; stored entries are
// left as they are and are never read before being written.
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded queue kept sorted in a chain of cells
// Higher priority first, then smaller arrival; full inserts are dropped,
// removes from an empty queue return an invalid entry.
// ----------------------------------------------------------------------------
module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  logic [PRIO_W-1:0] req_priority_req,
   input  logic [ARR_W-1:0]  req_arrival,
   input  logic [TAG_W-1:0]  req_tag,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_out_valid,
   output logic [PRIO_W-1:0] rsp_out_priority,
   output logic [ARR_W-1:0]  rsp_out_arrival,
   output logic [TAG_W-1:0]  rsp_out_tag,
   output logic              rsp_dropped,
   output logic              rsp_empty_now,
   output logic [OCC_W-1:0]  rsp_occupancy
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept, full, empty;
   spq_ctl_type      ctl;
   spq_entry_type    new_entry;
   spq_entry_type    cell_entry [DEPTH];
   logic             cell_before [DEPTH];

   logic              out_valid_ff, out_valid_in;
   spq_entry_type     out_entry_ff, out_entry_in;
   logic              dropped_ff, dropped_in;
   logic              empty_now_ff;
   logic [OCC_W-1:0]  occ_ff;

   // handshake: output register frees as it is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   assign new_entry = '{prio: req_priority_req, arr: req_arrival, tag: req_tag};

   // command for the chain
   always_comb begin
      ctl.ins = accept && (req_mode == MODE_INSERT) && !full;
      ctl.rem = accept && (req_mode == MODE_REMOVE) && !empty;
   end

   // cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_entry_type left_e, right_e;
      logic          left_b;
      if (i == 0) begin : g_head
         assign left_e = new_entry;
         assign left_b = 1'b0;
      end else begin : g_mid
         assign left_e = cell_entry[i-1];
         assign left_b = cell_before[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_e = cell_entry[i];
      end else begin : g_body
         assign right_e = cell_entry[i+1];
      end
      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (CNT_W'(i) < count_ff),
         .new_entry   (new_entry),
         .left_entry  (left_e),
         .left_before (left_b),
         .right_entry (right_e),
         .entry_ff    (cell_entry[i]),
         .lands       (cell_before[i])
      );
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (ctl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // result beat contents
   always_comb begin
      out_valid_in = ctl.rem;
      out_entry_in = ctl.rem ? cell_entry[0] : '0;
      dropped_in   = accept && (req_mode == MODE_INSERT) && full;
      rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (accept) begin
         out_valid_ff <= out_valid_in;
         out_entry_ff <= out_entry_in;
         dropped_ff   <= dropped_in;
         empty_now_ff <= (count_in == '0);
         occ_ff       <= OCC_W'(count_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_valid    = out_valid_ff;
   assign rsp_out_priority = out_entry_ff.prio;
   assign rsp_out_arrival  = out_entry_ff.arr;
   assign rsp_out_tag      = out_entry_ff.tag;
   assign rsp_dropped      = dropped_ff;
   assign rsp_empty_now    = empty_now_ff;
   assign rsp_occupancy    = occ_ff;

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_remove_valid : assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_REMOVE && !empty) |=> (rsp_valid && rsp_out_valid))
      else $error("remove from non-empty queue gave no entry");

   a_full_drop : assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_INSERT && full) |=> (rsp_dropped && $stable(count_ff)))
      else $error("insert into full queue not dropped");

   a_drop_no_entry : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_dropped && rsp_out_valid))
      else $error("dropped beat carries an entry");
`endif

endmodule

// ===== tb/sv/sorted_priority_queue_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test: self-checking bench for the sorted queue
// Drives insert and remove beats through the request channel, keeps its own
// sorted copy of the queue to predict every response beat, and compares the
// response fields one by one. Both channels stall at random.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test
   import spq_pkg::*;
;

   localparam int N_RANDOM    = 1625;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_WAIT  = 10;

   // predicts queue contents and checks response beats in order
   class spq_scoreboard;
      typedef struct {
         logic              out_valid;
         logic [PRIO_W-1:0] prio;
         logic [ARR_W-1:0]  arr;
         logic [TAG_W-1:0]  tag;
         logic              dropped;
         logic              empty_now;
         logic [OCC_W-1:0]  occupancy;
      } spq_result_type;

      spq_entry_type  held[$];
      spq_result_type awaited[$];
      int errors = 0;
      int n_checked = 0;
      int n_insert = 0;
      int n_remove = 0;
      int n_dropped = 0;
      int n_empty_remove = 0;
      int peak = 0;

      // higher priority wins, then smaller arrival; full ties lose
      function bit serves_first(spq_entry_type a, spq_entry_type b);
         if (a.prio != b.prio) return a.prio > b.prio;
         return a.arr < b.arr;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // apply an accepted request beat to the queue copy
      function void note_request(logic m, logic [PRIO_W-1:0] p,
                                 logic [ARR_W-1:0] a, logic [TAG_W-1:0] t);
         spq_result_type r;
         spq_entry_type  e;
         int pos;
         r = '{1'b0, '0, '0, '0, 1'b0, 1'b0, '0};
         if (m == MODE_INSERT) begin
            n_insert++;
            if (held.size() >= DEPTH) begin
               r.dropped = 1'b1;
               n_dropped++;
            end else begin
               e.prio = p;
               e.arr = a;
               e.tag = t;
               pos = 0;
               while (pos < held.size() && !serves_first(e, held[pos])) pos++;
               held.insert(pos, e);
            end
         end else begin
            n_remove++;
            if (held.size() > 0) begin
               e = held.pop_front();
               r.out_valid = 1'b1;
               r.prio = e.prio;
               r.arr = e.arr;
               r.tag = e.tag;
            end else begin
               n_empty_remove++;
            end
         end
         if (held.size() > peak) peak = held.size();
         r.empty_now = (held.size() == 0);
         r.occupancy = OCC_W'(held.size());
         awaited.push_back(r);
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("MISMATCH beat %0d: %s", n_checked, msg);
      endtask

      // compare one response beat against the oldest prediction
      task check_result(logic ov, logic [PRIO_W-1:0] p, logic [ARR_W-1:0] a,
                        logic [TAG_W-1:0] t, logic d, logic em,
                        logic [OCC_W-1:0] occ);
         spq_result_type w;
         if (awaited.size() == 0) begin
            report_mismatch("response with nothing outstanding");
         end else begin
            w = awaited.pop_front();
            if (ov !== w.out_valid)
               report_mismatch($sformatf("out_valid %b want %b", ov, w.out_valid));
            if (p !== w.prio)
               report_mismatch($sformatf("out_priority %0h want %0h", p, w.prio));
            if (a !== w.arr)
               report_mismatch($sformatf("out_arrival %0h want %0h", a, w.arr));
            if (t !== w.tag)
               report_mismatch($sformatf("out_tag %0h want %0h", t, w.tag));
            if (d !== w.dropped)
               report_mismatch($sformatf("dropped %b want %b", d, w.dropped));
            if (em !== w.empty_now)
               report_mismatch($sformatf("empty_now %b want %b", em, w.empty_now));
            if (occ !== w.occupancy)
               report_mismatch($sformatf("occupancy %0d want %0d", occ, w.occupancy));
         end
         n_checked++;
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_mode = MODE_INSERT;
   logic [PRIO_W-1:0] req_priority_req = '0;
   logic [ARR_W-1:0]  req_arrival = '0;
   logic [TAG_W-1:0]  req_tag = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_out_valid;
   logic [PRIO_W-1:0] rsp_out_priority;
   logic [ARR_W-1:0]  rsp_out_arrival;
   logic [TAG_W-1:0]  rsp_out_tag;
   logic              rsp_dropped;
   logic              rsp_empty_now;
   logic [OCC_W-1:0]  rsp_occupancy;

   bit steady = 1'b0;
   int stall_cycles = 0;
   spq_scoreboard sb = new();

   sorted_priority_queue i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_priority_req (req_priority_req),
      .req_arrival      (req_arrival),
      .req_tag          (req_tag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_priority (rsp_out_priority),
      .rsp_out_arrival  (rsp_out_arrival),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_dropped      (rsp_dropped),
      .rsp_empty_now    (rsp_empty_now),
      .rsp_occupancy    (rsp_occupancy)
   );

   always #6 clock = ~clock;

   // response side back-pressure, off during the steady stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 20);
      end
   end

   // take response beats and check them
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_out_valid, rsp_out_priority, rsp_out_arrival,
                         rsp_out_tag, rsp_dropped, rsp_empty_now, rsp_occupancy);
      end
   end

   // watchdog: no beat on either channel for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", stall_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // one request beat; optional random gap before it
   task automatic send_item(input logic m, input logic [PRIO_W-1:0] p,
                            input logic [ARR_W-1:0] a, input logic [TAG_W-1:0] t);
      if (!steady && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_priority_req <= p;
      req_arrival <= a;
      req_tag <= t;
      do @(posedge clock); while (!req_ready);
      sb.note_request(m, p, a, t);
   endtask

   // hold off the sender until all outstanding responses are back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int phase_kind;
      int phase_len;
      int rm_pct;
      bit narrow;
      logic m;
      logic [PRIO_W-1:0] p;
      logic [ARR_W-1:0] a;
      int pick;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty remove, extremes, arrival tie-break, full ties
      send_item(MODE_REMOVE, 8'h00, 16'h0000, 16'h0000);
      send_item(MODE_INSERT, 8'h00, 16'h0000, 16'h0000);
      send_item(MODE_INSERT, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_item(MODE_INSERT, 8'hFF, 16'h0000, 16'h1234);
      send_item(MODE_INSERT, 8'hFF, 16'h0000, 16'h5678);
      send_item(MODE_INSERT, 8'h80, 16'h8000, 16'hAAAA);
      send_item(MODE_INSERT, 8'h00, 16'hFFFF, 16'h5555);
      send_item(MODE_INSERT, 8'h80, 16'h8000, 16'h0001);
      repeat (8) send_item(MODE_REMOVE, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_item(MODE_INSERT, 8'h01, 16'h0001, 16'hC3C3);
      send_item(MODE_REMOVE, 8'h00, 16'h0000, 16'h0000);
      send_item(MODE_REMOVE, 8'h00, 16'h0000, 16'h0000);

      // random phases: filling, draining and mixed traffic
      sent = 0;
      while (sent < N_RANDOM) begin
         phase_kind = $urandom_range(2);
         phase_len = $urandom_range(20, 120);
         narrow = ($urandom_range(2) == 0);
         rm_pct = (phase_kind == 0) ? 15 : (phase_kind == 1) ? 85 : 50;
         for (int j = 0; j < phase_len && sent < N_RANDOM; j++) begin
            steady = (sent >= 700 && sent < 1000);
            if (sent == 400) wait_drained();
            m = ($urandom_range(99) < rm_pct) ? MODE_REMOVE : MODE_INSERT;
            pick = $urandom_range(15);
            // narrow ranges make priority and arrival ties common
            p = narrow ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom_range(255));
            a = narrow ? ARR_W'($urandom_range(3)) : ARR_W'($urandom_range(65535));
            if (pick == 0) begin
               p = 8'h00;
               a = 16'hFFFF;
            end else if (pick == 1) begin
               p = 8'hFF;
               a = 16'h0000;
            end
            send_item(m, p, a, TAG_W'($urandom_range(65535)));
            sent++;
         end
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d inserts (%0d refused when full), %0d removes (%0d on empty)",
               sb.n_insert, sb.n_dropped, sb.n_remove, sb.n_empty_remove);
      $display("peak occupancy %0d of %0d, %0d responses checked, %0d mismatches",
               sb.peak, DEPTH, sb.n_checked, sb.errors);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/sv/sorted_priority_queue_test.sv
